// File: hw/rtl/gccm_pkg.sv
// Shared types and constants for the graph coarsening column merge block.
package gccm_pkg;

  localparam int unsigned FineW   = 13;
  localparam int unsigned CoarseW = 12;
  localparam int unsigned SlotW   = 21;
  localparam int unsigned WInW    = 32;
  localparam int unsigned VSumW   = 34;
  localparam int unsigned ESumW   = 48;

  localparam logic [VSumW-1:0] VSumMax = '1;
  localparam logic [ESumW-1:0] ESumMax = '1;
  localparam logic [WInW-1:0]  OneQ16  = 32'h0001_0000;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_BEGIN  = 3'd1,
    OP_VWT    = 3'd2,
    OP_EDGE   = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NEW   = 2'd0,
    KIND_MERGE = 2'd1,
    KIND_COL   = 2'd2,
    KIND_GRAPH = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam logic CfgUseEdgeW = 1'b0;
  localparam logic CfgUseVertW = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [FineW-1:0]   fine_vertex;
    logic [CoarseW-1:0] coarse_vertex;
    logic [WInW-1:0]    weight_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SlotW-1:0]   slot;
    logic [CoarseW-1:0] neighbor;
    logic [VSumW-1:0]   weight_out;
    logic [ESumW-1:0]   edge_sum;
    logic [ESumW:0]     twice_total;
  } res_t;

  // Classified command held in the queue
  typedef struct packed {
    op_e                op;
    logic [FineW-1:0]   fine;
    logic [CoarseW-1:0] coarse;
    logic [WInW-1:0]    weight;
  } cmd_t;

  // Back end status toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

  typedef struct packed {
    logic use_edge_w;
    logic use_vert_w;
  } cfg_t;

endpackage

// File: hw/rtl/graph_coarsen_column_merge.sv
// Top level of the graph coarsening column merge block.
// A request is taken when start is high and busy is low; it goes into a two-deep
// command queue and the back end works it off in order. A fine edge in an open column
// goes through map RAM read, then slot-table RAM read, then decide and write, and the
// back end takes no further command until it is done; other commands need no RAM read.
// Each result appears on res_o for exactly one cycle with res_valid_o high and must
// be taken then. After reset and after each graph done result the slot table is
// cleared, one entry per cycle over all MAX_COARSE entries, during which busy stays
// high; configuration writes are taken at any time.
module graph_coarsen_column_merge #(
  parameter int unsigned MAX_FINE    = 8192,
  parameter int unsigned MAX_COARSE  = 4096,
  parameter int unsigned MAX_ENTRIES = 1048576
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  gccm_pkg::req_t req_i,
  output logic           res_valid_o,
  output gccm_pkg::res_t res_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic           cfg_data_i
);
  import gccm_pkg::*;

  cfg_t     cfg_q;
  bk_stat_t stat;
  logic     head_vld;
  cmd_t     head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{use_edge_w: 1'b1, use_vert_w: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgUseEdgeW: cfg_q.use_edge_w <= cfg_data_i;
        CfgUseVertW: cfg_q.use_vert_w <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gccm_front #(.MAX_FINE(MAX_FINE)) u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i, .stat_i(stat),
    .head_vld_o(head_vld), .head_o(head)
  );

  gccm_back #(
    .MAX_FINE(MAX_FINE), .MAX_COARSE(MAX_COARSE), .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .head_vld_i(head_vld), .head_i(head),
    .stat_o(stat), .res_vld_o(res_valid_o), .res_o
  );

endmodule

// File: hw/rtl/gccm_ram.sv
// Generic simple dual-port RAM with registered read.
module gccm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/gccm_front.sv
// Front end: accepts requests, drops no-op requests, queues commands.
module gccm_front #(
  parameter int unsigned MAX_FINE = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gccm_pkg::req_t    req_i,
  input  gccm_pkg::bk_stat_t stat_i,
  output logic              head_vld_o,
  output gccm_pkg::cmd_t    head_o
);
  import gccm_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       q_q [Depth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep, push, fine_ok;

  assign busy = (cnt_q == 2'(Depth)) || stat_i.clearing;

  // Classify: unknown codes and out-of-range fine indexes do nothing
  assign fine_ok = 32'(req_i.fine_vertex) < 32'(MAX_FINE);
  always_comb begin
    unique case (req_i.operation)
      OP_LOAD, OP_EDGE:            keep = fine_ok;
      OP_BEGIN, OP_VWT, OP_FINISH: keep = 1'b1;
      default:                     keep = 1'b0;
    endcase
  end

  assign push = start && !busy && keep;

  // Queue pointers
  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = stat_i.pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(stat_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= '{op: op_e'(req_i.operation), fine: req_i.fine_vertex,
                     coarse: req_i.coarse_vertex, weight: req_i.weight_in};
    end
  end

  assign head_vld_o = cnt_q != 2'd0;
  assign head_o     = q_q[rp_q];

endmodule

// File: hw/rtl/gccm_back.sv
// Back end: map and slot table lookups, sums, result generation.
module gccm_back #(
  parameter int unsigned MAX_FINE    = 8192,
  parameter int unsigned MAX_COARSE  = 4096,
  parameter int unsigned MAX_ENTRIES = 1048576
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gccm_pkg::cfg_t     cfg_i,
  input  logic               head_vld_i,
  input  gccm_pkg::cmd_t     head_i,
  output gccm_pkg::bk_stat_t stat_o,
  output logic               res_vld_o,
  output gccm_pkg::res_t     res_o
);
  import gccm_pkg::*;

  localparam int unsigned FAW = MAX_FINE > 1 ? $clog2(MAX_FINE) : 1;
  localparam int unsigned CAW = MAX_COARSE > 1 ? $clog2(MAX_COARSE) : 1;
  localparam int unsigned ECW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MAP, ST_SLOT
  } state_e;

  state_e             state_q, state_d;
  logic [CAW-1:0]     clr_q, clr_d;
  logic               open_q, open_d;
  logic [CoarseW-1:0] cur_q, cur_d, nb_q, nb_d;
  logic [ECW-1:0]     cnt_q, cnt_d, start_q, start_d;
  logic [VSumW-1:0]   vsum_q, vsum_d;
  logic [ESumW-1:0]   csum_q, csum_d, gsum_q, gsum_d;
  logic [WInW-1:0]    w_q, w_d;
  logic               res_vld_q, res_vld_d;
  res_t               res_q, res_d;

  logic               map_we;
  logic [CoarseW-1:0] map_rdata;
  logic               slot_we;
  logic [CAW-1:0]     slot_waddr, slot_raddr;
  logic [ECW:0]       slot_wdata, slot_rdata;
  logic               pop;

  logic [VSumW:0]     vs_add;
  logic [ESumW:0]     cs_add, gs_add;
  logic [VSumW-1:0]   vs_sat;
  logic [ESumW-1:0]   cs_sat, gs_sat;
  logic [WInW-1:0]    vw_eff;

  gccm_ram #(.Width(CoarseW), .Depth(MAX_FINE)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(FAW'(head_i.fine)), .wdata_i(head_i.coarse),
    .raddr_i(FAW'(head_i.fine)), .rdata_o(map_rdata)
  );

  gccm_ram #(.Width(ECW + 1), .Depth(MAX_COARSE)) u_slot (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rdata)
  );

  // Saturating adders
  assign vw_eff = cfg_i.use_vert_w ? head_i.weight : OneQ16;
  assign vs_add = (VSumW+1)'(vsum_q) + (VSumW+1)'(vw_eff);
  assign vs_sat = vs_add > (VSumW+1)'(VSumMax) ? VSumMax : vs_add[VSumW-1:0];
  assign cs_add = (ESumW+1)'(csum_q) + (ESumW+1)'(w_q);
  assign cs_sat = cs_add[ESumW] ? ESumMax : cs_add[ESumW-1:0];
  assign gs_add = (ESumW+1)'(gsum_q) + (ESumW+1)'(csum_q);
  assign gs_sat = gs_add[ESumW] ? ESumMax : gs_add[ESumW-1:0];

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    open_d     = open_q;
    cur_d      = cur_q;
    nb_d       = nb_q;
    cnt_d      = cnt_q;
    start_d    = start_q;
    vsum_d     = vsum_q;
    csum_d     = csum_q;
    gsum_d     = gsum_q;
    w_d        = w_q;
    res_vld_d  = 1'b0;
    res_d      = '0;
    pop        = 1'b0;
    map_we     = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = CAW'(nb_q);
    slot_wdata = {1'b1, cnt_q};
    slot_raddr = CAW'(map_rdata);

    unique case (state_q)
      // Mark every slot entry unseen, one per cycle
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == CAW'(MAX_COARSE - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (head_vld_i) begin
          pop = 1'b1;
          unique case (head_i.op)
            OP_LOAD: map_we = 1'b1;
            OP_BEGIN: begin
              if (open_q) begin
                res_vld_d = 1'b1;
                res_d     = '{kind: KIND_COL, slot: SlotW'(start_q), neighbor: cur_q,
                              weight_out: vsum_q, edge_sum: csum_q, twice_total: '0};
                gsum_d    = gs_sat;
              end
              open_d  = 1'b1;
              cur_d   = head_i.coarse;
              start_d = cnt_q;
              vsum_d  = '0;
              csum_d  = '0;
            end
            OP_VWT: begin
              if (open_q) vsum_d = vs_sat;
            end
            OP_EDGE: begin
              if (open_q) begin
                w_d     = cfg_i.use_edge_w ? head_i.weight : OneQ16;
                state_d = ST_MAP;
              end
            end
            OP_FINISH: begin
              res_vld_d = 1'b1;
              if (open_q) begin
                res_d  = '{kind: KIND_COL, slot: SlotW'(start_q), neighbor: cur_q,
                           weight_out: vsum_q, edge_sum: csum_q, twice_total: '0};
                gsum_d = gs_sat;
                open_d = 1'b0;
              end else begin
                res_d   = '{kind: KIND_GRAPH, slot: SlotW'(cnt_q), neighbor: '0,
                            weight_out: '0, edge_sum: gsum_q,
                            twice_total: {gsum_q, 1'b0}};
                cnt_d   = '0;
                start_d = '0;
                gsum_d  = '0;
                state_d = ST_CLEAR;
              end
            end
            default: ;
          endcase
        end
      end

      // Map data ready: filter, then look up the slot table
      ST_MAP: begin
        nb_d = map_rdata;
        if (32'(map_rdata) >= 32'(MAX_COARSE) || map_rdata == cur_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SLOT;
        end
      end

      // Slot data ready: merge, or append while fewer than MAX_ENTRIES entries exist
      ST_SLOT: begin
        state_d = ST_IDLE;
        if (slot_rdata[ECW] && slot_rdata[ECW-1:0] >= start_q) begin
          csum_d    = cs_sat;
          res_vld_d = 1'b1;
          res_d     = '{kind: KIND_MERGE, slot: SlotW'(slot_rdata[ECW-1:0]),
                        neighbor: '0, weight_out: VSumW'(w_q), edge_sum: '0,
                        twice_total: '0};
        end else if (cnt_q < ECW'(MAX_ENTRIES)) begin
          csum_d    = cs_sat;
          slot_we   = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          res_vld_d = 1'b1;
          res_d     = '{kind: KIND_NEW, slot: SlotW'(cnt_q), neighbor: nb_q,
                        weight_out: VSumW'(w_q), edge_sum: '0, twice_total: '0};
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      open_q    <= 1'b0;
      cur_q     <= '0;
      cnt_q     <= '0;
      start_q   <= '0;
      vsum_q    <= '0;
      csum_q    <= '0;
      gsum_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      open_q    <= open_d;
      cur_q     <= cur_d;
      cnt_q     <= cnt_d;
      start_q   <= start_d;
      vsum_q    <= vsum_d;
      csum_q    <= csum_d;
      gsum_q    <= gsum_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    nb_q  <= nb_d;
    w_q   <= w_d;
    res_q <= res_d;
  end

  assign stat_o    = '{pop: pop, clearing: state_q == ST_CLEAR};
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

// File: hw/rtl/gccm_checker.sv
// Port-level checks for the column merge block, bound to the top level.
module gccm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy,
  input logic           res_valid_o,
  input gccm_pkg::res_t res_o
);
  import gccm_pkg::*;

  // Graph done reports twice its total
  a_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_GRAPH |-> res_o.twice_total == {res_o.edge_sum, 1'b0})
    else $error("twice_total mismatch");

  // Entry results carry no sums
  a_entry_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_NEW || res_o.kind == KIND_MERGE)
    |-> res_o.edge_sum == '0 && res_o.twice_total == '0)
    else $error("entry result with sums");

  // Merge carries no neighbor
  a_merge_nb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_MERGE |-> res_o.neighbor == '0)
    else $error("merge with neighbor");

  // Graph done starts the slot-table clear
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_GRAPH |=> busy)
    else $error("no clear after graph done");

endmodule

bind graph_coarsen_column_merge gccm_checker u_gccm_checker (
  .clk_i, .rst_ni, .busy, .res_valid_o, .res_o
);

// File: bench/tb_graph_coarsen_column_merge.sv
// Self-checking testbench for the graph coarsening column merge block.
module tb_graph_coarsen_column_merge;
  timeunit 1ns;
  timeprecision 1ps;
  import gccm_pkg::*;

  localparam int unsigned NumFine     = 8192;
  localparam int unsigned NumCoarse   = 4096;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned ItemsPerPh  = 108;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic res_valid_o;
  res_t res_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic cfg_data_i = 1'b0;

  graph_coarsen_column_merge dut (
    .clk_i, .rst_ni, .start, .busy, .req_i(req),
    .res_valid_o, .res_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the block state
  logic [CoarseW-1:0] map_mem [NumFine];
  logic [SlotW-1:0]   slot_mem [NumCoarse];
  logic               slot_seen [NumCoarse];
  logic [SlotW-1:0]   n_entries = '0;
  logic [SlotW-1:0]   col_first = '0;
  logic [CoarseW-1:0] col_id = '0;
  logic [VSumW-1:0]   vert_sum = '0;
  logic [ESumW-1:0]   col_sum = '0;
  logic [ESumW-1:0]   graph_sum = '0;
  logic               col_open = 1'b0;
  logic               edge_w_on = 1'b1;
  logic               vert_w_on = 1'b1;

  res_t expected_q [$];
  req_t pending_q [$];
  logic [FineW-1:0] mapped_fines [$];

  int unsigned idle_pct = 6;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_graphs = 0;
  int unsigned n_mismatch = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_queued = 0;

  initial begin
    for (int i = 0; i < NumCoarse; i++) slot_seen[i] = 1'b0;
  end

  function automatic res_t make_res(kind_e k, logic [SlotW-1:0] s, logic [CoarseW-1:0] nb,
                                    logic [VSumW-1:0] w, logic [ESumW-1:0] es,
                                    logic [ESumW:0] tt);
    res_t r;
    r.kind = k; r.slot = s; r.neighbor = nb;
    r.weight_out = w; r.edge_sum = es; r.twice_total = tt;
    return r;
  endfunction

  function automatic logic [ESumW-1:0] esum_add(logic [ESumW-1:0] a, logic [ESumW-1:0] b);
    logic [ESumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ESumW] ? ESumMax : s[ESumW-1:0];
  endfunction

  // Closing a column reports it and folds its edge sum into the graph total
  task automatic close_col();
    expected_q.push_back(make_res(KIND_COL, col_first, col_id, vert_sum, col_sum, '0));
    graph_sum = esum_add(graph_sum, col_sum);
    col_open = 1'b0;
  endtask

  // Expected behavior of one accepted request
  task automatic predict_contraction(req_t r);
    logic [VSumW:0] vs;
    logic [WInW-1:0] w;
    logic [CoarseW-1:0] nb;
    w = r.weight_in;
    case (r.operation)
      OP_LOAD: map_mem[r.fine_vertex] = r.coarse_vertex;
      OP_BEGIN: begin
        if (col_open) close_col();
        col_open = 1'b1;
        col_id = r.coarse_vertex;
        col_first = n_entries;
        vert_sum = '0;
        col_sum = '0;
      end
      OP_VWT: if (col_open) begin
        if (!vert_w_on) w = OneQ16;
        vs = {1'b0, vert_sum} + (VSumW+1)'(w);
        vert_sum = vs[VSumW] ? VSumMax : vs[VSumW-1:0];
      end
      OP_EDGE: if (col_open) begin
        nb = map_mem[r.fine_vertex];
        if (!edge_w_on) w = OneQ16;
        if (nb != col_id) begin
          if (slot_seen[nb] && slot_mem[nb] >= col_first) begin
            col_sum = esum_add(col_sum, ESumW'(w));
            expected_q.push_back(make_res(KIND_MERGE, slot_mem[nb], '0, VSumW'(w), '0, '0));
          end else begin
            col_sum = esum_add(col_sum, ESumW'(w));
            slot_seen[nb] = 1'b1;
            slot_mem[nb] = n_entries;
            expected_q.push_back(make_res(KIND_NEW, n_entries, nb, VSumW'(w), '0, '0));
            n_entries++;
          end
        end
      end
      OP_FINISH: begin
        if (col_open) close_col();
        else begin
          expected_q.push_back(make_res(KIND_GRAPH, n_entries, '0, '0, graph_sum,
                                        {graph_sum, 1'b0}));
          n_entries = '0;
          col_first = '0;
          graph_sum = '0;
          for (int i = 0; i < NumCoarse; i++) slot_seen[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Driver: requests go out from the pending queue with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_contraction(req);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req <= pending_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (res_valid_o) begin
        n_results++;
        if (res_o.kind == KIND_GRAPH) n_graphs++;
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("ERROR: unexpected result %h", res_o);
        end else begin
          res_t e;
          e = expected_q.pop_front();
          if (res_o.kind != e.kind || res_o.slot != e.slot || res_o.neighbor != e.neighbor ||
              res_o.weight_out != e.weight_out || res_o.edge_sum != e.edge_sum ||
              res_o.twice_total != e.twice_total) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("ERROR: kind/slot/nb/w/es/tt exp %0d %0d %0d %h %h %h got %0d %0d %0d %h %h %h",
                       e.kind, e.slot, e.neighbor, e.weight_out, e.edge_sum, e.twice_total,
                       res_o.kind, res_o.slot, res_o.neighbor, res_o.weight_out,
                       res_o.edge_sum, res_o.twice_total);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no request or result for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_req(op_e op, logic [FineW-1:0] f, logic [CoarseW-1:0] c,
                          logic [WInW-1:0] w);
    req_t r;
    r.operation = op; r.fine_vertex = f; r.coarse_vertex = c; r.weight_in = w;
    pending_q.push_back(r);
    n_queued++;
  endtask

  function automatic logic [WInW-1:0] rand_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(32'h3_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_map(logic [FineW-1:0] f, logic [CoarseW-1:0] c);
    push_req(OP_LOAD, f, c, $urandom);
    mapped_fines.push_back(f);
  endtask

  // One random graph: map loads, a few columns, then finish
  task automatic queue_graph();
    logic [CoarseW-1:0] ids [6];
    int unsigned n_ids;
    req_t junk;
    n_ids = $urandom_range(1, 6);
    for (int i = 0; i < 6; i++) ids[i] = CoarseW'($urandom);
    repeat ($urandom_range(2, 8)) load_map(FineW'($urandom), ids[$urandom_range(n_ids - 1)]);
    repeat ($urandom_range(1, 5)) begin
      push_req(OP_BEGIN, FineW'($urandom), ($urandom_range(4) == 0) ? 12'($urandom)
                                    : ids[$urandom_range(n_ids - 1)], $urandom);
      repeat ($urandom_range(0, 3))
        push_req(OP_VWT, FineW'($urandom), CoarseW'($urandom), rand_weight());
      repeat ($urandom_range(0, 8))
        push_req(OP_EDGE, mapped_fines[$urandom_range(mapped_fines.size() - 1)],
                 CoarseW'($urandom), rand_weight());
      if ($urandom_range(9) == 0) begin
        junk = req_t'(60'({$urandom, $urandom}));
        junk.operation = 3'($urandom_range(5, 7));
        pending_q.push_back(junk);
        n_queued++;
      end
    end
    push_req(OP_FINISH, FineW'($urandom), CoarseW'($urandom), $urandom);
    if ($urandom_range(4) != 0) begin
      push_req(OP_FINISH, FineW'($urandom), CoarseW'($urandom), $urandom);
      // stray requests with no open column
      if ($urandom_range(3) == 0)
        push_req(OP_EDGE, FineW'($urandom), CoarseW'($urandom), $urandom);
      if ($urandom_range(3) == 0)
        push_req(OP_VWT, FineW'($urandom), CoarseW'($urandom), $urandom);
    end
  endtask

  // Idle means nothing pending or being driven, nothing expected and the block not busy
  task automatic wait_drained();
    while (pending_q.size() != 0 || start || expected_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CfgUseEdgeW) edge_w_on = val;
    else vert_w_on = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [1:0] cfg_plan [6];
    int unsigned ph_start;
    cfg_plan = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b00, 2'b11};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(CfgUseEdgeW, 1'b1);
    write_cfg(CfgUseVertW, 1'b1);

    // Directed: extremes, self-edge, merge, saturation, odd cases
    push_req(OP_FINISH, '0, '0, '0);
    load_map('0, '0);
    load_map('1, '1);
    load_map(13'd5, 12'hAAA);
    load_map(13'd6, 12'h555);
    push_req(OP_VWT, '0, '0, '1);
    push_req(OP_EDGE, 13'd5, '0, '1);
    push_req(OP_BEGIN, '1, '0, '0);
    repeat (5) push_req(OP_VWT, '1, '1, '1);
    push_req(OP_EDGE, '0, '0, '1);
    push_req(OP_EDGE, '1, '0, '1);
    push_req(OP_EDGE, '1, '1, '0);
    push_req(OP_EDGE, 13'd5, '0, '0);
    push_req(OP_BEGIN, '0, '1, '1);
    push_req(OP_EDGE, 13'd5, '0, 32'h8000_0001);
    push_req(OP_EDGE, 13'd6, '0, '1);
    push_req(OP_EDGE, '1, '0, 32'h1234_5678);
    push_req(OP_EDGE, 13'd5, '0, 32'h0001_0000);
    pending_q.push_back(req_t'({3'd7, 13'h1FFF, 12'hFFF, 32'hFFFF_FFFF}));
    pending_q.push_back(req_t'({3'd5, 13'h0, 12'h0, 32'h0}));
    push_req(OP_FINISH, '1, '1, '1);
    push_req(OP_FINISH, '0, '0, '0);

    // Random phases over settings and gap patterns
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_cfg(CfgUseEdgeW, cfg_plan[ph][1]);
      write_cfg(CfgUseVertW, cfg_plan[ph][0]);
      idle_pct = (ph < 2) ? 6 : (ph < 4) ? 67 : 0;
      ph_start = n_queued;
      while (n_queued - ph_start < ItemsPerPh) queue_graph();
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d requests, %0d results checked, %0d graphs completed",
             n_accepted, n_results, n_graphs);
    $display("Weight settings swept in all four combinations; %0d mismatches", n_mismatch);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: graph_coarsen_column_merge.f
hw/rtl/gccm_pkg.sv
hw/rtl/gccm_ram.sv
hw/rtl/gccm_front.sv
hw/rtl/gccm_back.sv
hw/rtl/graph_coarsen_column_merge.sv
hw/rtl/gccm_checker.sv
bench/tb_graph_coarsen_column_merge.sv
